### rtl/core/cpu_addressing_mode_unit_defines.svh
// Assertion macros for the CPU addressing mode unit.
// Included by modules that check their own control logic; needs clk_i and rst_ni in scope.
`ifndef CPU_ADDRESSING_MODE_UNIT_DEFINES_SVH
`define CPU_ADDRESSING_MODE_UNIT_DEFINES_SVH

// Check a same-cycle implication, disabled while reset is asserted.
`define CAM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("addressing unit check failed");

// Check an implication in the next cycle, disabled while reset is asserted.
`define CAM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("addressing unit sequencing check failed");

`endif

### rtl/core/cam_pkg.sv
// Shared types and constants for the CPU addressing mode unit.
// No dependencies; imported by cam_calc and cpu_addressing_mode_unit.
`default_nettype none

package cam_pkg;

  // Addressing mode codes
  typedef enum logic [3:0] {
    MODE_ACC  = 4'd0,
    MODE_ABS  = 4'd1,
    MODE_ABSX = 4'd2,
    MODE_ABSY = 4'd3,
    MODE_IMM  = 4'd4,
    MODE_IMPL = 4'd5,
    MODE_IND  = 4'd6,
    MODE_INDX = 4'd7,
    MODE_INDY = 4'd8,
    MODE_REL  = 4'd9,
    MODE_ZP   = 4'd10,
    MODE_ZPX  = 4'd11,
    MODE_ZPY  = 4'd12
  } mode_e;

  // Fixed cycle counts
  localparam logic [3:0] CYC_ACC  = 4'd2;
  localparam logic [3:0] CYC_IMM  = 4'd2;
  localparam logic [3:0] CYC_INDX = 4'd6;
  localparam logic [3:0] CYC_ZPY  = 4'd4;
  localparam logic [3:0] CYC_REL  = 4'd3;

  // Last byte of a page, used by the indirect jump wrap
  localparam logic [7:0] PAGE_LAST = 8'hFF;

  // Request fields as captured at acceptance
  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] pc;
    logic [7:0]  x_index;
    logic [7:0]  y_index;
    logic [7:0]  operand_low;
    logic [7:0]  operand_high;
    logic [7:0]  pointer_low_byte;
    logic [7:0]  pointer_high_byte;
    logic [2:0]  base_cycles;
    logic        page_penalty_enable;
  } req_t;

  // Result fields
  typedef struct packed {
    logic [15:0] effective_address;
    logic [15:0] next_pc;
    logic [3:0]  cycle_count;
    logic        page_crossed;
    logic        is_accumulator;
    logic [15:0] pointer_low_addr;
    logic [15:0] pointer_high_addr;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/cpu_addressing_mode_unit.sv
// Addressing mode unit: each accepted request passes through the request register,
// then the result register, and its result shows with done_o.
// Throughput one request per clock; busy_o stays low, so start_i may be held high.
// Results show for exactly one cycle with done_o and are never held off.
// Reset (rst_ni low, asynchronous) drops any request in flight; payload is not reset.
`default_nettype none

module cpu_addressing_mode_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  action_i,
  input  logic [15:0] pc_i,
  input  logic [7:0]  x_index_i,
  input  logic [7:0]  y_index_i,
  input  logic [7:0]  operand_low_i,
  input  logic [7:0]  operand_high_i,
  input  logic [7:0]  pointer_low_byte_i,
  input  logic [7:0]  pointer_high_byte_i,
  input  logic [2:0]  base_cycles_i,
  input  logic        page_penalty_enable_i,
  output logic        done_o,
  output logic [15:0] effective_address_o,
  output logic [15:0] next_pc_o,
  output logic [3:0]  cycle_count_o,
  output logic        page_crossed_o,
  output logic        is_accumulator_o,
  output logic [15:0] pointer_low_addr_o,
  output logic [15:0] pointer_high_addr_o
);
  import cam_pkg::*;
  `include "cpu_addressing_mode_unit_defines.svh"

  req_t req_q;
  logic req_valid_q;
  res_t res_d;
  res_t res_q;
  logic done_q;
  logic accept;

  // Accept every cycle; nothing downstream can stall
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Track which pipeline slots hold a request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      req_valid_q <= accept;
      done_q      <= req_valid_q;
    end
  end

  // Capture the request fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.action              <= action_i;
      req_q.pc                  <= pc_i;
      req_q.x_index             <= x_index_i;
      req_q.y_index             <= y_index_i;
      req_q.operand_low         <= operand_low_i;
      req_q.operand_high        <= operand_high_i;
      req_q.pointer_low_byte    <= pointer_low_byte_i;
      req_q.pointer_high_byte   <= pointer_high_byte_i;
      req_q.base_cycles         <= base_cycles_i;
      req_q.page_penalty_enable <= page_penalty_enable_i;
    end
  end

  cam_calc u_calc (
    .req_i (req_q),
    .res_o (res_d)
  );

  // Hold the result for its strobe cycle
  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      res_q <= res_d;
    end
  end

  assign done_o              = done_q;
  assign effective_address_o = res_q.effective_address;
  assign next_pc_o           = res_q.next_pc;
  assign cycle_count_o       = res_q.cycle_count;
  assign page_crossed_o      = res_q.page_crossed;
  assign is_accumulator_o    = res_q.is_accumulator;
  assign pointer_low_addr_o  = res_q.pointer_low_addr;
  assign pointer_high_addr_o = res_q.pointer_high_addr;

  `CAM_ASSERT_NEXT(a_req_to_done, req_valid_q, done_o)
  `CAM_ASSERT_NOW(a_done_has_src, done_o, $past(req_valid_q))
  `CAM_ASSERT_NOW(a_acc_no_mem, done_o && is_accumulator_o,
    effective_address_o == 16'h0000 && pointer_low_addr_o == 16'h0000 && !page_crossed_o)
  `CAM_ASSERT_NOW(a_acc_cycles, done_o && is_accumulator_o, cycle_count_o == CYC_ACC)
  `CAM_ASSERT_NOW(a_cycle_bound, done_o, cycle_count_o <= 4'd8)

endmodule

`default_nettype wire

### rtl/core/cam_calc.sv
// Combinational address generation for one registered request.
// Depends on cam_pkg for the mode codes, request and result structs.
`default_nettype none

module cam_calc (
  input  cam_pkg::req_t req_i,
  output cam_pkg::res_t res_o
);
  import cam_pkg::*;

  logic [15:0] abs_addr;
  logic [15:0] ptr_val;
  logic [15:0] pc_one;
  logic [15:0] pc_two;
  logic [15:0] abs_idx;
  logic [15:0] ptr_idx;
  logic [15:0] rel_tgt;
  logic [7:0]  zp_x;
  logic [7:0]  zp_y;
  logic [7:0]  zp_x1;
  logic [7:0]  lo_1;
  logic [3:0]  base4;
  logic        abs_cross;
  logic        ptr_cross;
  logic        rel_cross;

  // Form the shared sums
  always_comb begin
    abs_addr  = {req_i.operand_high, req_i.operand_low};
    ptr_val   = {req_i.pointer_high_byte, req_i.pointer_low_byte};
    pc_one    = req_i.pc + 16'd1;
    pc_two    = req_i.pc + 16'd2;
    abs_idx   = abs_addr + {8'h00,
                 (mode_e'(req_i.action) == MODE_ABSX) ? req_i.x_index : req_i.y_index};
    ptr_idx   = ptr_val + {8'h00, req_i.y_index};
    rel_tgt   = pc_one + {{8{req_i.operand_low[7]}}, req_i.operand_low};
    zp_x      = req_i.operand_low + req_i.x_index;
    zp_y      = req_i.operand_low + req_i.y_index;
    zp_x1     = zp_x + 8'd1;
    lo_1      = req_i.operand_low + 8'd1;
    base4     = {1'b0, req_i.base_cycles};
    abs_cross = abs_idx[15:8] != req_i.operand_high;
    ptr_cross = ptr_idx[15:8] != req_i.pointer_high_byte;
    rel_cross = rel_tgt[15:8] != pc_one[15:8];
  end

  // Select the result by mode; unused codes answer as implied
  always_comb begin
    res_o.effective_address = 16'h0000;
    res_o.next_pc           = req_i.pc;
    res_o.cycle_count       = base4;
    res_o.page_crossed      = 1'b0;
    res_o.is_accumulator    = 1'b0;
    res_o.pointer_low_addr  = 16'h0000;
    res_o.pointer_high_addr = 16'h0000;
    unique case (mode_e'(req_i.action))
      MODE_ACC: begin
        res_o.is_accumulator = 1'b1;
        res_o.cycle_count    = CYC_ACC;
      end
      MODE_ABS: begin
        res_o.effective_address = abs_addr;
        res_o.next_pc           = pc_two;
      end
      MODE_ABSX, MODE_ABSY: begin
        res_o.effective_address = abs_idx;
        res_o.page_crossed      = abs_cross;
        res_o.cycle_count       = base4 + {3'd0, abs_cross & req_i.page_penalty_enable};
        res_o.next_pc           = pc_two;
      end
      MODE_IMM: begin
        res_o.effective_address = req_i.pc;
        res_o.next_pc           = pc_one;
        res_o.cycle_count       = CYC_IMM;
      end
      MODE_IMPL: begin
        res_o.next_pc = req_i.pc;
      end
      MODE_IND: begin
        // Pointer on the last byte of a page wraps to that page's start
        res_o.pointer_low_addr  = abs_addr;
        res_o.pointer_high_addr = (req_i.operand_low == PAGE_LAST) ?
                                  {req_i.operand_high, 8'h00} : abs_addr + 16'd1;
        res_o.effective_address = ptr_val;
        res_o.next_pc           = pc_two;
      end
      MODE_INDX: begin
        res_o.pointer_low_addr  = {8'h00, zp_x};
        res_o.pointer_high_addr = {8'h00, zp_x1};
        res_o.effective_address = ptr_val;
        res_o.next_pc           = pc_one;
        res_o.cycle_count       = CYC_INDX;
      end
      MODE_INDY: begin
        res_o.pointer_low_addr  = {8'h00, req_i.operand_low};
        res_o.pointer_high_addr = {8'h00, lo_1};
        res_o.effective_address = ptr_idx;
        res_o.page_crossed      = ptr_cross;
        res_o.cycle_count       = base4 + {3'd0, ptr_cross & req_i.page_penalty_enable};
        res_o.next_pc           = pc_one;
      end
      MODE_REL: begin
        // Branch taken; page test against the address after the offset byte
        res_o.effective_address = rel_tgt;
        res_o.page_crossed      = rel_cross;
        res_o.cycle_count       = CYC_REL + {3'd0, rel_cross};
        res_o.next_pc           = pc_one;
      end
      MODE_ZP: begin
        res_o.effective_address = {8'h00, req_i.operand_low};
        res_o.next_pc           = pc_one;
      end
      MODE_ZPX: begin
        res_o.effective_address = {8'h00, zp_x};
        res_o.next_pc           = pc_one;
      end
      MODE_ZPY: begin
        res_o.effective_address = {8'h00, zp_y};
        res_o.next_pc           = pc_one;
        res_o.cycle_count       = CYC_ZPY;
      end
      default: begin
        res_o.next_pc = req_i.pc;
      end
    endcase
  end

endmodule

`default_nettype wire
